// ===== src/hcm_pkg.sv =====
// Shared constants, types and codes of the hash containment matcher.
`default_nettype none
package hcm_pkg;
	localparam int PAIR_DEPTH     = 4096;
	localparam int BLOCK_DEPTH    = 256;
	localparam int POOL_DEPTH     = 4096;
	localparam int BITMAP_MAX_LOG = 16;
	localparam int MAX_HASHES     = 128;
	localparam int BM_MIN_LOG     = 12;
	localparam int BM_WORD        = 16;
	localparam int BM_AW          = BITMAP_MAX_LOG - 4;
	localparam int PAIR_AW        = 12;
	localparam int BLOCK_AW       = 8;
	localparam int POOL_AW        = 12;
	localparam int NUM_W          = 15;
	localparam int DEN_W          = 8;

	typedef enum logic [2:0] {
		OP_LOAD_BLOCK = 3'd0,
		OP_LOAD_PAIR  = 3'd1,
		OP_BEGIN_OBJ  = 3'd2,
		OP_CREDIT     = 3'd3,
		OP_QUERY      = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		REG_ALL_REGIONS = 2'd0,
		REG_BITMAP_BITS = 2'd1,
		REG_PAIR_COUNT  = 2'd2,
		REG_BLOCK_COUNT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] hash;
		logic [7:0]  blk;
		logic [6:0]  slot;
	} pair_ent_t;

	typedef struct packed {
		logic [11:0] start;
		logic [7:0]  len;
		logic [2:0]  norm;
		logic [31:0] region;
	} blk_ent_t;

	typedef struct packed {
		logic             go;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;
endpackage
`default_nettype wire

// ===== src/hash_containment_matcher_core.sv =====
// Top level: stores, configuration registers and the item sequencer.
// Usage:
// - Items enter on start while busy is low; all fields are sampled then.
// - Each item gives one result beat on done, one cycle wide; the receiver
//   cannot stall, so the result must be taken in that cycle.
// - Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are
//   always ready; write them only while the block is idle.
// - Load block and begin object go straight to the finish state; load pair
//   reads and writes a bitmap word; query reads the block entry, then runs
//   the divider. Credit ends on a bitmap miss, else it binary-searches the
//   pairs and walks the matching ones, clearing a block's hit marks when it
//   is first touched in an object. One item at a time: the pair and block
//   memories each have a single read port that the sequencer steps through.
// - After reset the presence bitmap is cleared one 16-bit word per cycle,
//   all 4096 words, with busy high; configuration writes are taken meanwhile.
`default_nettype none
module hash_containment_matcher_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  operation,
	input  wire logic [11:0] pair_index,
	input  wire logic [31:0] hash,
	input  wire logic [7:0]  block_index,
	input  wire logic [6:0]  slot,
	input  wire logic [11:0] span_start,
	input  wire logic [7:0]  hash_count,
	input  wire logic [2:0]  norm,
	input  wire logic [31:0] region_bits,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [12:0] cfg_data,
	output logic             done,
	output logic             accepted,
	output logic             bitmap_pass,
	output logic [12:0]      blocks_credited,
	output logic [7:0]       matched_count,
	output logic [7:0]       declared_count,
	output logic [6:0]       percent
);
	import hcm_pkg::*;

	typedef enum logic [17:0] {
		ST_IDLE   = 18'h00001,
		ST_CLR    = 18'h00002,
		ST_BM_RD  = 18'h00004,
		ST_BM_WR  = 18'h00008,
		ST_CR_RD  = 18'h00010,
		ST_CR_CHK = 18'h00020,
		ST_SR_RD  = 18'h00040,
		ST_SR_CMP = 18'h00080,
		ST_WK_RD  = 18'h00100,
		ST_WK_CHK = 18'h00200,
		ST_WK_BLK = 18'h00400,
		ST_WK_CLR = 18'h00800,
		ST_HIT_RD = 18'h01000,
		ST_HIT    = 18'h02000,
		ST_Q_RD   = 18'h04000,
		ST_Q_DAT  = 18'h08000,
		ST_Q_DIV  = 18'h10000,
		ST_FIN    = 18'h20000
	} state_t;

	state_t state_q;

	// configuration
	logic        all_regions_q;
	logic [4:0]  bitmap_bits_q;
	logic [12:0] pair_count_q;
	logic [8:0]  block_count_q;
	logic [31:0] gen_q;
	logic [BLOCK_DEPTH-1:0] vld_q;

	// latched item
	logic [31:0] h_q;
	logic [7:0]  bi_q;
	logic [2:0]  nm_q;
	logic [31:0] sm_q;

	// sequencer registers
	logic [11:0] clr_q;
	logic [12:0] lo_q, hi_q, mid_q;
	logic [7:0]  b_q;
	logic [6:0]  psl_q;
	logic [7:0]  cnt_q;
	logic [7:0]  seen_q;
	blk_ent_t    ent_q;

	// results
	logic        done_q, acc_q, pass_q;
	logic [12:0] got_q;
	logic [7:0]  match_q, decl_q;
	logic [6:0]  pct_q;

	// memories
	pair_ent_t        pair_mem [PAIR_DEPTH];
	blk_ent_t         blk_mem [BLOCK_DEPTH];
	logic [31:0]      stamp_mem [BLOCK_DEPTH];
	logic [7:0]       seen_mem [BLOCK_DEPTH];
	logic [BM_WORD-1:0] bm_mem [1 << BM_AW];
	logic             hit_mem [POOL_DEPTH];

	pair_ent_t          pair_rd_q;
	blk_ent_t           blk_rd_q;
	logic [31:0]        stamp_rd_q;
	logic [7:0]         seen_rd_q;
	logic               vld_rd_q;
	logic [BM_WORD-1:0] bm_rd_q;
	logic               hit_rd_q;

	logic [PAIR_AW-1:0]  pair_ra, pair_wa;
	logic                pair_we;
	pair_ent_t           pair_wd;
	logic                blk_we;
	logic [BLOCK_AW-1:0] blk_ra;
	logic                stamp_we, seen_we;
	logic [7:0]          seen_wd;
	logic [BM_AW-1:0]    bm_ra, bm_wa;
	logic                bm_we;
	logic [BM_WORD-1:0]  bm_wd;
	logic [POOL_AW-1:0]  hit_ra, hit_wa;
	logic                hit_we, hit_wd;

	logic        accept;
	logic [4:0]  bb;
	logic [15:0] bm_key;
	logic [12:0] n_pairs;
	logic [8:0]  live_blks;
	logic [12:0] mid;
	logic [12:0] span_end;
	logic        blk_ok;
	logic        stale;
	logic        q_ok;
	logic [7:0]  q_seen;
	logic [14:0] prod;
	logic [31:0] gen_nx;

	div_req_t div_req;
	div_rsp_t div_rsp;

	hcm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign accept    = start && !busy;
	assign busy      = state_q != ST_IDLE;
	assign cfg_ready = 1'b1;

	always_comb begin
		bb = bitmap_bits_q;
		if (bb < 5'(BM_MIN_LOG))
			bb = 5'(BM_MIN_LOG);
		if (bb > 5'(BITMAP_MAX_LOG))
			bb = 5'(BITMAP_MAX_LOG);
	end
	assign bm_key    = h_q[15:0] & ~(16'hffff << bb);
	assign n_pairs   = pair_count_q > 13'(PAIR_DEPTH) ? 13'(PAIR_DEPTH) : pair_count_q;
	assign live_blks = block_count_q > 9'(BLOCK_DEPTH) ? 9'(BLOCK_DEPTH) : block_count_q;
	assign mid       = lo_q + ((hi_q - lo_q) >> 1);
	assign span_end  = {1'b0, span_start} + {5'd0, hash_count};
	assign blk_ok    = (psl_q < blk_rd_q.len[6:0] || blk_rd_q.len[7])
		&& blk_rd_q.norm == nm_q
		&& (all_regions_q || (blk_rd_q.region & sm_q) != 32'd0);
	assign stale     = !vld_rd_q || stamp_rd_q != gen_q;
	assign q_ok      = {1'b0, bi_q} < live_blks && blk_rd_q.len != 8'd0;
	assign q_seen    = stale ? 8'd0 : seen_rd_q;
	assign prod      = 15'(q_seen) * 15'd100;
	assign gen_nx    = gen_q + 32'd1;

	// memory port control
	always_comb begin
		pair_ra  = mid[PAIR_AW-1:0];
		pair_we  = 1'b0;
		pair_wa  = pair_index;
		pair_wd  = '{hash: hash, blk: block_index, slot: slot};
		blk_we   = 1'b0;
		blk_ra   = b_q;
		stamp_we = 1'b0;
		seen_we  = 1'b0;
		seen_wd  = 8'd0;
		bm_ra    = bm_key[15:4];
		bm_we    = 1'b0;
		bm_wa    = bm_key[15:4];
		bm_wd    = bm_rd_q | (BM_WORD'(1) << bm_key[3:0]);
		hit_ra   = ent_q.start + {5'd0, psl_q};
		hit_we   = 1'b0;
		hit_wa   = ent_q.start + {4'd0, cnt_q};
		hit_wd   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && operation == OP_LOAD_BLOCK
					&& hash_count <= 8'(MAX_HASHES) && span_end <= 13'(POOL_DEPTH))
					blk_we = 1'b1;
				if (accept && operation == OP_LOAD_PAIR)
					pair_we = 1'b1;
			end
			ST_CLR: begin
				bm_we = 1'b1;
				bm_wa = clr_q;
				bm_wd = '0;
			end
			ST_BM_WR: bm_we = 1'b1;
			ST_WK_RD: pair_ra = lo_q[PAIR_AW-1:0];
			ST_WK_CHK: blk_ra = pair_rd_q.blk;
			ST_WK_BLK: begin
				if (blk_ok && stale) begin
					stamp_we = 1'b1;
					seen_we  = 1'b1;
				end
			end
			ST_WK_CLR: hit_we = 1'b1;
			ST_HIT: begin
				if (!hit_rd_q) begin
					hit_we  = 1'b1;
					hit_wa  = hit_ra;
					hit_wd  = 1'b1;
					seen_we = 1'b1;
					seen_wd = seen_q == 8'hff ? seen_q : seen_q + 8'd1;
				end
			end
			ST_Q_RD: blk_ra = bi_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pair_we)
			pair_mem[pair_wa] <= pair_wd;
		pair_rd_q <= pair_mem[pair_ra];
	end

	always_ff @(posedge clk) begin
		if (blk_we)
			blk_mem[block_index] <= '{start: span_start, len: hash_count,
				norm: norm, region: region_bits};
		blk_rd_q <= blk_mem[blk_ra];
	end

	always_ff @(posedge clk) begin
		if (stamp_we)
			stamp_mem[b_q] <= gen_q;
		stamp_rd_q <= stamp_mem[blk_ra];
	end

	always_ff @(posedge clk) begin
		if (seen_we)
			seen_mem[b_q] <= seen_wd;
		seen_rd_q <= seen_mem[blk_ra];
	end

	always_ff @(posedge clk) begin
		if (bm_we)
			bm_mem[bm_wa] <= bm_wd;
		bm_rd_q <= bm_mem[bm_ra];
	end

	always_ff @(posedge clk) begin
		if (hit_we)
			hit_mem[hit_wa] <= hit_wd;
		hit_rd_q <= hit_mem[hit_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_rd_q <= 1'b0;
		else
			vld_rd_q <= vld_q[blk_ra];
	end

	// configuration registers, generation and stamp valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			all_regions_q <= 1'b0;
			bitmap_bits_q <= 5'(BM_MIN_LOG);
			pair_count_q  <= '0;
			block_count_q <= '0;
			gen_q         <= 32'd1;
			vld_q         <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_ALL_REGIONS: all_regions_q <= cfg_data[0];
					REG_BITMAP_BITS: bitmap_bits_q <= cfg_data[4:0];
					REG_PAIR_COUNT:  pair_count_q  <= cfg_data;
					REG_BLOCK_COUNT: block_count_q <= cfg_data[8:0];
					default: ;
				endcase
			end
			if (accept && operation == OP_BEGIN_OBJ) begin
				all_regions_q <= 1'b0;
				if (gen_nx == 32'd0) begin
					gen_q <= 32'd1;
					vld_q <= '0;
				end else begin
					gen_q <= gen_nx;
				end
			end
			if (stamp_we)
				vld_q[b_q] <= 1'b1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 12'd1;
					if (clr_q == '1)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						case (operation)
							OP_LOAD_PAIR: state_q <= ST_BM_RD;
							OP_CREDIT:    state_q <= ST_CR_RD;
							OP_QUERY:     state_q <= ST_Q_RD;
							default:      state_q <= ST_FIN;
						endcase
					end
				end
				ST_BM_RD:  state_q <= ST_BM_WR;
				ST_BM_WR:  state_q <= ST_FIN;
				ST_CR_RD:  state_q <= ST_CR_CHK;
				ST_CR_CHK: state_q <= bm_rd_q[bm_key[3:0]] ? ST_SR_RD : ST_FIN;
				ST_SR_RD:  state_q <= lo_q < hi_q ? ST_SR_CMP : ST_WK_RD;
				ST_SR_CMP: state_q <= ST_SR_RD;
				ST_WK_RD:  state_q <= lo_q < n_pairs ? ST_WK_CHK : ST_FIN;
				ST_WK_CHK: begin
					if (pair_rd_q.hash != h_q)
						state_q <= ST_FIN;
					else if ({1'b0, pair_rd_q.blk} >= live_blks)
						state_q <= ST_WK_RD;
					else
						state_q <= ST_WK_BLK;
				end
				ST_WK_BLK: begin
					if (!blk_ok)
						state_q <= ST_WK_RD;
					else if (stale)
						state_q <= ST_WK_CLR;
					else
						state_q <= ST_HIT_RD;
				end
				ST_WK_CLR: begin
					if (cnt_q + 8'd1 >= ent_q.len)
						state_q <= ST_HIT_RD;
				end
				ST_HIT_RD: state_q <= ST_HIT;
				ST_HIT:    state_q <= ST_WK_RD;
				ST_Q_RD:   state_q <= ST_Q_DAT;
				ST_Q_DAT:  state_q <= q_ok ? ST_Q_DIV : ST_FIN;
				ST_Q_DIV: begin
					if (div_rsp.done)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		div_req.go  = state_q == ST_Q_DAT && q_ok;
		div_req.num = prod;
		div_req.den = blk_rd_q.len;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					h_q     <= hash;
					bi_q    <= block_index;
					nm_q    <= norm;
					sm_q    <= region_bits;
					acc_q   <= 1'b0;
					pass_q  <= 1'b0;
					got_q   <= '0;
					match_q <= '0;
					decl_q  <= '0;
					pct_q   <= '0;
					case (operation)
						OP_LOAD_BLOCK: acc_q <= hash_count <= 8'(MAX_HASHES)
							&& span_end <= 13'(POOL_DEPTH);
						OP_LOAD_PAIR:  acc_q <= 1'b1;
						OP_BEGIN_OBJ:  acc_q <= 1'b1;
						OP_CREDIT:     acc_q <= 1'b1;
						OP_QUERY:      acc_q <= 1'b0;
						default:       acc_q <= 1'b0;
					endcase
				end
			end
			ST_CR_CHK: begin
				pass_q <= bm_rd_q[bm_key[3:0]];
				lo_q   <= '0;
				hi_q   <= n_pairs;
			end
			ST_SR_RD: mid_q <= mid;
			ST_SR_CMP: begin
				if (pair_rd_q.hash < h_q)
					lo_q <= mid_q + 13'd1;
				else
					hi_q <= mid_q;
			end
			ST_WK_CHK: begin
				b_q   <= pair_rd_q.blk;
				psl_q <= pair_rd_q.slot;
				if (pair_rd_q.hash == h_q && {1'b0, pair_rd_q.blk} >= live_blks)
					lo_q <= lo_q + 13'd1;
			end
			ST_WK_BLK: begin
				ent_q  <= blk_rd_q;
				cnt_q  <= '0;
				seen_q <= stale ? 8'd0 : seen_rd_q;
				if (!blk_ok)
					lo_q <= lo_q + 13'd1;
			end
			ST_WK_CLR: cnt_q <= cnt_q + 8'd1;
			ST_HIT: begin
				lo_q <= lo_q + 13'd1;
				if (!hit_rd_q)
					got_q <= got_q + 13'd1;
			end
			ST_Q_DAT: begin
				if (q_ok) begin
					acc_q   <= 1'b1;
					match_q <= q_seen;
					decl_q  <= blk_rd_q.len;
				end
			end
			ST_Q_DIV: begin
				if (div_rsp.done)
					pct_q <= div_rsp.quo > 15'd100 ? 7'd100 : div_rsp.quo[6:0];
			end
			default: ;
		endcase
	end

	assign done            = done_q;
	assign accepted        = acc_q;
	assign bitmap_pass     = pass_q;
	assign blocks_credited = got_q;
	assign matched_count   = match_q;
	assign declared_count  = decl_q;
	assign percent         = pct_q;
endmodule
`default_nettype wire

// ===== src/hcm_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module hcm_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hcm_pkg::div_req_t req,
	output hcm_pkg::div_rsp_t      rsp
);
	import hcm_pkg::*;

	logic             run_q;
	logic [3:0]       cnt_q;
	logic [DEN_W:0]   rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic             fits;

	assign rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(NUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (run_q) begin
			rem_q <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule
`default_nettype wire

// ===== tb/hcm_checker.sv =====
// Checker: watches item, config and result beats, predicts each result and compares.
module hcm_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [2:0]  operation,
	input  wire logic [11:0] pair_index,
	input  wire logic [31:0] hash,
	input  wire logic [7:0]  block_index,
	input  wire logic [6:0]  slot,
	input  wire logic [11:0] span_start,
	input  wire logic [7:0]  hash_count,
	input  wire logic [2:0]  norm,
	input  wire logic [31:0] region_bits,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [12:0] cfg_data,
	input  wire logic        done,
	input  wire logic        accepted,
	input  wire logic        bitmap_pass,
	input  wire logic [12:0] blocks_credited,
	input  wire logic [7:0]  matched_count,
	input  wire logic [7:0]  declared_count,
	input  wire logic [6:0]  percent,
	output int               fails,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import hcm_pkg::*;

	typedef struct {
		bit        acc;
		bit        pass;
		bit [12:0] cred;
		bit [7:0]  mat;
		bit [7:0]  dec;
		bit [6:0]  pct;
	} outcome_t;

	bit [31:0] pr_hash [PAIR_DEPTH];
	bit [7:0]  pr_blk  [PAIR_DEPTH];
	bit [6:0]  pr_slot [PAIR_DEPTH];
	bit [11:0] bk_start [BLOCK_DEPTH];
	bit [7:0]  bk_len   [BLOCK_DEPTH];
	bit [2:0]  bk_norm  [BLOCK_DEPTH];
	bit [31:0] bk_region[BLOCK_DEPTH];
	bit [31:0] bk_stamp [BLOCK_DEPTH];
	bit [7:0]  bk_seen  [BLOCK_DEPTH];
	bit        marks    [POOL_DEPTH];
	bit [65535:0] presence;
	bit [31:0] gen;
	bit        all_regions;
	bit [4:0]  bm_bits;
	bit [12:0] pair_cnt;
	bit [8:0]  blk_cnt;
	outcome_t  expected_q[$];

	task automatic report(input string field, input int got, input int exp);
		$display("mismatch %s: got %0d expected %0d at %0t", field, got, exp, $realtime);
		fails++;
	endtask

	function automatic int bm_index(input bit [31:0] h);
		int b;
		b = bm_bits;
		if (b < BM_MIN_LOG) b = BM_MIN_LOG;
		if (b > BITMAP_MAX_LOG) b = BITMAP_MAX_LOG;
		return h & ((1 << b) - 1);
	endfunction

	function automatic int live_pairs();
		return (pair_cnt > PAIR_DEPTH) ? PAIR_DEPTH : pair_cnt;
	endfunction

	function automatic int live_blocks();
		return (blk_cnt > BLOCK_DEPTH) ? BLOCK_DEPTH : blk_cnt;
	endfunction

	function automatic int credit_blocks(input bit [31:0] h, input bit [2:0] nm,
			input bit [31:0] mask);
		int lo, hi, n, nb, got, mid, b, at;
		lo = 0;
		hi = live_pairs();
		n = hi;
		nb = live_blocks();
		got = 0;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (pr_hash[mid] < h) lo = mid + 1;
			else hi = mid;
		end
		for (; lo < n && pr_hash[lo] == h; lo++) begin
			b = pr_blk[lo];
			if (b >= nb || pr_slot[lo] >= bk_len[b]) continue;
			if (bk_norm[b] != nm) continue;
			if (!all_regions && (bk_region[b] & mask) == 0) continue;
			if (bk_stamp[b] != gen) begin
				bk_stamp[b] = gen;
				bk_seen[b] = 0;
				for (int i = 0; i < bk_len[b]; i++) marks[bk_start[b] + i] = 0;
			end
			at = bk_start[b] + pr_slot[lo];
			if (!marks[at]) begin
				marks[at] = 1;
				if (bk_seen[b] != 8'hff) bk_seen[b]++;
				got++;
			end
		end
		return got;
	endfunction

	function automatic outcome_t predict_item();
		outcome_t r;
		int seen, pct;
		r = '{default: 0};
		case (operation)
			OP_LOAD_BLOCK: begin
				if (hash_count <= MAX_HASHES && span_start + hash_count <= POOL_DEPTH) begin
					bk_start[block_index] = span_start;
					bk_len[block_index] = hash_count;
					bk_norm[block_index] = norm;
					bk_region[block_index] = region_bits;
					r.acc = 1;
				end
			end
			OP_LOAD_PAIR: begin
				pr_hash[pair_index] = hash;
				pr_blk[pair_index] = block_index;
				pr_slot[pair_index] = slot;
				presence[bm_index(hash)] = 1;
				r.acc = 1;
			end
			OP_BEGIN_OBJ: begin
				gen++;
				all_regions = 0;
				if (gen == 0) begin
					for (int i = 0; i < BLOCK_DEPTH; i++) begin
						bk_stamp[i] = 0;
						bk_seen[i] = 0;
					end
					gen = 1;
				end
				r.acc = 1;
			end
			OP_CREDIT: begin
				r.acc = 1;
				if (presence[bm_index(hash)]) begin
					r.pass = 1;
					r.cred = 13'(credit_blocks(hash, norm, region_bits));
				end
			end
			OP_QUERY: begin
				if (block_index < live_blocks() && bk_len[block_index] != 0) begin
					seen = (bk_stamp[block_index] == gen) ? bk_seen[block_index] : 0;
					pct = seen * 100 / bk_len[block_index];
					if (pct > 100) pct = 100;
					r.acc = 1;
					r.mat = 8'(seen);
					r.dec = bk_len[block_index];
					r.pct = 7'(pct);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t e;
		if (!arst_n) begin
			for (int i = 0; i < BLOCK_DEPTH; i++) begin
				bk_stamp[i] = 0;
				bk_seen[i] = 0;
			end
			presence = '0;
			gen = 1;
			all_regions = 0;
			bm_bits = 12;
			pair_cnt = 0;
			blk_cnt = 0;
			expected_q.delete();
			pending = 0;
		end else begin
			if (done) begin
				if (expected_q.size() == 0) begin
					report("unexpected result beat", 1, 0);
				end else begin
					e = expected_q.pop_front();
					if (accepted !== e.acc) report("accepted", accepted, e.acc);
					if (bitmap_pass !== e.pass) report("bitmap_pass", bitmap_pass, e.pass);
					if (blocks_credited !== e.cred)
						report("blocks_credited", blocks_credited, e.cred);
					if (matched_count !== e.mat) report("matched_count", matched_count, e.mat);
					if (declared_count !== e.dec)
						report("declared_count", declared_count, e.dec);
					if (percent !== e.pct) report("percent", percent, e.pct);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ALL_REGIONS: all_regions = cfg_data[0];
					REG_BITMAP_BITS: bm_bits = cfg_data[4:0];
					REG_PAIR_COUNT:  pair_cnt = cfg_data;
					REG_BLOCK_COUNT: blk_cnt = cfg_data[8:0];
					default: ;
				endcase
			end
			if (start && !busy) expected_q.push_back(predict_item());
			pending = expected_q.size();
		end
	end

	initial fails = 0;
endmodule

// ===== tb/testbench.sv =====
// Testbench top: clock, reset, stimulus and verdict for the containment matcher.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import hcm_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic [2:0]  operation = 0;
	logic [11:0] pair_index = 0;
	logic [31:0] hash = 0;
	logic [7:0]  block_index = 0;
	logic [6:0]  slot = 0;
	logic [11:0] span_start = 0;
	logic [7:0]  hash_count = 0;
	logic [2:0]  norm = 0;
	logic [31:0] region_bits = 0;
	logic        cfg_valid = 0;
	logic [1:0]  cfg_index = 0;
	logic [12:0] cfg_data = 0;
	logic        busy, cfg_ready, done, accepted, bitmap_pass;
	logic [12:0] blocks_credited;
	logic [7:0]  matched_count, declared_count;
	logic [6:0]  percent;
	int          fails, pending;

	int          blk_len_tb[BLOCK_DEPTH];
	bit [31:0]   hash_pool[$];

	hash_containment_matcher_core DUT (.*);
	hcm_checker u_checker (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#150ms;
		$display("Simulation FAILED");
		$finish;
	end

	task automatic send_item(input int op, input int pi, input int h,
			input int bi, input int sl, input int fh,
			input int hc, input int nm, input int sm, input bit gap);
		int w;
		w = gap ? $urandom_range(0, 13) : 0;
		repeat (w) @(negedge clk);
		operation = 3'(op);
		pair_index = 12'(pi);
		hash = 32'(h);
		block_index = 8'(bi);
		slot = 7'(sl);
		span_start = 12'(fh);
		hash_count = 8'(hc);
		norm = 3'(nm);
		region_bits = 32'(sm);
		start = 1;
		do @(posedge clk); while (busy);
		@(negedge clk);
		start = 0;
	endtask

	task automatic wait_idle();
		do @(negedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input reg_idx_t idx, input int value);
		@(negedge clk);
		cfg_index = idx;
		cfg_data = 13'(value);
		cfg_valid = 1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	function automatic bit [31:0] rand_mask();
		case ($urandom_range(0, 3))
			0: return 32'h0;
			1: return 32'hffffffff;
			default: return 32'h1 << $urandom_range(0, 31) | $urandom & $urandom;
		endcase
	endfunction

	task automatic load_block(input int bi, input bit gap);
		int hc, fh;
		case ($urandom_range(0, 9))
			0: hc = 0;
			1: hc = MAX_HASHES;
			default: hc = $urandom_range(1, 8);
		endcase
		fh = ($urandom_range(0, 5) == 0) ? POOL_DEPTH - hc : $urandom_range(0, POOL_DEPTH - hc);
		blk_len_tb[bi] = hc;
		send_item(OP_LOAD_BLOCK, $urandom, $urandom, bi, $urandom, fh, hc,
			$urandom_range(0, 1) ? 0 : $urandom_range(0, 7), rand_mask(), gap);
	endtask

	task automatic bad_block_load();
		int hc;
		hc = $urandom_range(0, 1) ? $urandom_range(MAX_HASHES + 1, 255) :
			$urandom_range(2, MAX_HASHES);
		send_item(OP_LOAD_BLOCK, $urandom, $urandom, $urandom_range(0, 255), $urandom,
			POOL_DEPTH - $urandom_range(1, hc - 1), hc, $urandom, $urandom, 1);
	endtask

	task automatic load_pairs(input int np, input int nb, input bit gap);
		bit [31:0] hs[];
		int b, psize;
		hash_pool.delete();
		psize = (np / 4 < 1) ? 1 : np / 4;
		for (int i = 0; i < psize; i++) hash_pool.push_back($urandom);
		hs = new[np];
		foreach (hs[i]) hs[i] = hash_pool[$urandom_range(0, psize - 1)];
		hs.sort();
		for (int i = 0; i < np; i++) begin
			if (nb == 0 || $urandom_range(0, 11) == 0) begin
				send_item(OP_LOAD_PAIR, i, hs[i], $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, gap);
			end else begin
				b = $urandom_range(0, nb - 1);
				send_item(OP_LOAD_PAIR, i, hs[i], b,
					(blk_len_tb[b] == 0) ? 7'($urandom) : 7'($urandom_range(0, blk_len_tb[b] - 1)),
					$urandom, $urandom, $urandom, $urandom, gap);
			end
		end
	endtask

	task automatic random_items(input int count, input int nb, input int np);
		bit [31:0] h;
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (hash_pool.size() != 0 && pick < 55) begin
				h = hash_pool[$urandom_range(0, hash_pool.size() - 1)];
				if ($urandom_range(0, 7) == 0) h ^= 32'h1 << $urandom_range(16, 31);
				send_item(OP_CREDIT, $urandom, h, $urandom, $urandom, $urandom, $urandom,
					$urandom_range(0, 2) ? 0 : $urandom_range(0, 7), rand_mask(), 1);
			end else if (pick < 70) begin
				send_item(OP_CREDIT, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, 1);
			end else if (pick < 86) begin
				send_item(OP_QUERY, $urandom, $urandom,
					(nb != 0 && $urandom_range(0, 5) != 0) ? $urandom_range(0, nb - 1) : $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom, 1);
			end else if (pick < 91) begin
				send_item(OP_BEGIN_OBJ, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, 1);
			end else if (pick < 94 && np != 0) begin
				send_item(OP_LOAD_PAIR, $urandom_range(0, np - 1), hash_pool[0],
					(nb != 0) ? $urandom_range(0, nb - 1) : $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, 1);
			end else if (pick < 97) begin
				bad_block_load();
			end else begin
				send_item($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, 1);
			end
		end
	endtask

	// one phase: reload blocks and pairs, then configure and run objects
	task automatic run_phase(input int nb, input int np, input int cnt_blocks,
			input int cnt_pairs, input int bits, input int count, input bit gap);
		wait_idle();
		write_reg(REG_BITMAP_BITS, $urandom_range(0, 31));
		for (int b = 0; b < nb; b++) load_block(b, gap);
		bad_block_load();
		load_pairs(np, nb, gap);
		wait_idle();
		write_reg(REG_BITMAP_BITS, bits);
		write_reg(REG_PAIR_COUNT, cnt_pairs);
		write_reg(REG_BLOCK_COUNT, cnt_blocks);
		send_item(OP_BEGIN_OBJ, 0, 0, 0, 0, 0, 0, 0, 0, 1);
		wait_idle();
		write_reg(REG_ALL_REGIONS, $urandom_range(0, 1));
		random_items(count, nb, np);
	endtask

	initial begin
		int nb, np;
		repeat (10) @(negedge clk);
		arst_n = 1;
		// empty tables: queries refused, credits miss the bitmap, unknown codes, oversized block loads
		send_item(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(OP_CREDIT, 0, 'hffffffff, 0, 0, 0, 0, 7, 'hffffffff, 1);
		send_item(5, 0, 0, 0, 0, 0, 0, 0, 0, 1);
		send_item(6, 4095, 0, 255, 127, 4095, 255, 7, 0, 1);
		send_item(7, 0, 0, 0, 0, 0, 0, 0, 0, 1);
		send_item(OP_BEGIN_OBJ, 0, 0, 0, 0, 0, 0, 0, 0, 1);
		send_item(OP_LOAD_BLOCK, 0, 0, 0, 0, 4000, 129, 0, 0, 1);
		send_item(OP_LOAD_BLOCK, 0, 0, 0, 0, 4000, 128, 0, 0, 1);
		run_phase(4, 8, 4, 8, 12, 20, 1);
		run_phase(0, 0, 0, 0, 16, 15, 1);
		for (int p = 0; p < 3; p++) begin
			nb = $urandom_range(1, 24);
			np = $urandom_range(1, 64);
			run_phase(nb, np, nb, np, $urandom_range(0, 31), 75, 1);
		end
		// full block table, block count and bitmap size past their ranges
		run_phase(BLOCK_DEPTH, 64, 511, 64, 31, 80, 0);
		wait_idle();
		repeat (50) @(negedge clk);
		if (fails == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end
endmodule

// ===== filelist.f =====
src/hcm_pkg.sv
src/hcm_div.sv
src/hash_containment_matcher_core.sv
tb/hcm_checker.sv
tb/testbench.sv
